[hdl/button_press_qualifier_assert.svh]
// ----------------------------------------------------------------------------
// button_press_qualifier_assert.svh
// assertion macros for the button press qualifier, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_QUALIFIER_ASSERT_SVH
`define BUTTON_PRESS_QUALIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define BPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BPQ_ASSERT_NOW(label, ante, cons)
`define BPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/bpq_pkg.sv]
// ----------------------------------------------------------------------------
// bpq_pkg
// shared types and codes of the button press qualifier
// ----------------------------------------------------------------------------
package bpq_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int TIME_BITS_DEF   = 16;
	localparam int LIMIT_BITS      = 16;
	localparam int FIELD_BUTTONS   = 4;

	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS = 2'd1;

	localparam logic [LIMIT_BITS-1:0] DEBOUNCE_RESET   = 16'd2;
	localparam logic [LIMIT_BITS-1:0] LONG_PRESS_RESET = 16'd100;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic [1:0] ST_RELEASED = 2'd0;
	localparam logic [1:0] ST_DOWN     = 2'd1;
	localparam logic [1:0] ST_PRESSED  = 2'd2;
	localparam logic [1:0] ST_LONG     = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [3:0]  pressed_levels;
		logic [1:0]  release_id;
		logic [15:0] backoff_periods;
	} bpq_sample_t;

	typedef struct packed {
		logic [1:0] up_status;
		logic [1:0] down_status;
		logic [1:0] extra_status;
		logic [1:0] power_status;
	} bpq_status_t;

	typedef struct packed {
		logic sample;
		logic qualify;
		logic clear;
	} bpq_ctrl_t;

endpackage

[hdl/button_press_qualifier.sv]
// ----------------------------------------------------------------------------
// button_press_qualifier
// debounce and long-press qualification of up to four buttons
//
//   channel  | handshake                 | beat
//   ---------+---------------------------+-------------------------------
//   sample   | sample_valid/sample_stall | kind, levels, release, backoff
//   status   | status_valid/status_stall | four 2-bit button states
//   cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// one beat per cycle while sample_stall is low; each button updates its
// state and counter in the accept cycle, the result is registered for status
// an output register plus one skid entry keeps sample accepted while one
// result waits; sample_stall rises only when both entries are full
// reset gives released buttons, zero held times, no backoff, default limits
// cfg_ready is always high
// ----------------------------------------------------------------------------
module button_press_qualifier #(
	parameter int NUM_BUTTONS = bpq_pkg::NUM_BUTTONS_DEF,
	parameter int TIME_BITS   = bpq_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  bpq_pkg::bpq_sample_t              sample,
	output logic                              status_valid,
	input  logic                              status_stall,
	output bpq_pkg::bpq_status_t              status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bpq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bpq_pkg::LIMIT_BITS-1:0]     cfg_data
);
	import bpq_pkg::*;

	`include "button_press_qualifier_assert.svh"

	logic [LIMIT_BITS-1:0] debounce_q, long_press_q;
	logic [15:0]           backoff_q;
	logic                  accept, is_sample, is_release;
	logic                  out_valid_q, skid_valid_q, taken;
	bpq_status_t           result, out_q, skid_q;
	bpq_ctrl_t             ctrl [NUM_BUTTONS];
	logic [1:0]            status_d [NUM_BUTTONS];
	logic [FIELD_BUTTONS-1:0][1:0] field_st;

	assign cfg_ready    = 1'b1;
	assign sample_stall = skid_valid_q;
	assign accept       = sample_valid & ~skid_valid_q;
	assign is_sample    = accept & (sample.kind == KIND_SAMPLE);
	assign is_release   = accept & (sample.kind == KIND_RELEASE);
	assign taken        = out_valid_q & ~status_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_DEBOUNCE) begin
				debounce_q <= cfg_data;
			end
			if (cfg_index == CFG_LONG_PRESS) begin
				long_press_q <= cfg_data;
			end
		end
	end

	// backoff counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backoff_q <= '0;
		end else if (is_release) begin
			backoff_q <= sample.backoff_periods;
		end else if (is_sample && backoff_q != '0) begin
			backoff_q <= backoff_q - 1'b1;
		end
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		logic level;
		if (b < FIELD_BUTTONS) begin : g_lvl
			assign level = sample.pressed_levels[b];
		end else begin : g_nolvl
			assign level = 1'b0;
		end
		assign ctrl[b].sample  = is_sample;
		assign ctrl[b].qualify = (backoff_q == '0);
		assign ctrl[b].clear   = is_release && (32'(sample.release_id) == b);

		bpq_button #(
			.TIME_BITS(TIME_BITS)
		) u_button (
			.clk             (clk),
			.arst_n          (arst_n),
			.ctrl            (ctrl[b]),
			.level           (level),
			.debounce_limit  (debounce_q),
			.long_press_limit(long_press_q),
			.status_next     (status_d[b])
		);
	end

	for (genvar j = 0; j < FIELD_BUTTONS; j++) begin : g_field
		if (j < NUM_BUTTONS) begin : g_have
			assign field_st[j] = status_d[j];
		end else begin : g_none
			assign field_st[j] = ST_RELEASED;
		end
	end

	assign result.up_status    = field_st[0];
	assign result.down_status  = field_st[1];
	assign result.extra_status = field_st[2];
	assign result.power_status = field_st[3];

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !taken) begin
			if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !taken) begin
			if (accept) begin
				skid_q <= result;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (accept) begin
			out_q <= result;
		end
	end

	assign status_valid = out_valid_q;
	assign status       = out_q;

	`BPQ_ASSERT_NOW(a_skid_implies_out, skid_valid_q, out_valid_q)
	`BPQ_ASSERT_NEXT(a_skid_holds, skid_valid_q && status_stall, skid_valid_q)
	`BPQ_ASSERT_NEXT(a_backoff_load, is_release, backoff_q == $past(sample.backoff_periods))
	`BPQ_ASSERT_NEXT(a_backoff_dec, is_sample && |backoff_q, backoff_q == $past(backoff_q) - 1'b1)

endmodule

[hdl/bpq_button.sv]
// ----------------------------------------------------------------------------
// bpq_button
// state and saturating held-time counter of one button
// ----------------------------------------------------------------------------
module bpq_button #(
	parameter int TIME_BITS = bpq_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpq_pkg::bpq_ctrl_t            ctrl,
	input  logic                          level,
	input  logic [bpq_pkg::LIMIT_BITS-1:0] debounce_limit,
	input  logic [bpq_pkg::LIMIT_BITS-1:0] long_press_limit,
	output logic [1:0]                    status_next
);
	import bpq_pkg::*;

	localparam int CMP_BITS = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;

	logic [1:0]           status_q, status_d;
	logic [TIME_BITS-1:0] held_q, held_d, held_inc;
	logic [CMP_BITS-1:0]  held_ext, deb_ext, long_ext;

	always_comb begin
		held_inc = (&held_q) ? held_q : held_q + 1'b1;
		held_ext = CMP_BITS'(held_inc);
		deb_ext  = CMP_BITS'(debounce_limit);
		long_ext = CMP_BITS'(long_press_limit);
		status_d = status_q;
		held_d   = held_q;
		if (ctrl.clear) begin
			status_d = ST_RELEASED;
			held_d   = '0;
		end else if (ctrl.sample) begin
			held_d = held_inc;
			if (ctrl.qualify) begin
				if (level) begin
					if (status_q == ST_RELEASED) begin
						status_d = ST_DOWN;
						held_d   = '0;
					end else if (status_q == ST_DOWN && held_ext > long_ext) begin
						status_d = ST_LONG;
					end
				end else begin
					if (status_q == ST_DOWN && held_ext > deb_ext) begin
						status_d = ST_PRESSED;
						held_d   = '0;
					end else if (status_q != ST_PRESSED) begin
						status_d = ST_RELEASED;
						held_d   = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_RELEASED;
			held_q   <= '0;
		end else begin
			status_q <= status_d;
			held_q   <= held_d;
		end
	end

	assign status_next = status_d;

endmodule
